>>> sv/slcp_pkg.sv
// Shared types and constants of the serial line command parser.
// No dependencies; compiled first.
package slcp_pkg;

   localparam int unsigned LineDepthDefault = 1024;
   localparam int unsigned LineLenWidth     = 11;
   localparam int unsigned BaudWidth        = 16;
   localparam int unsigned ByteWidth        = 8;

   localparam logic [ByteWidth-1:0] CharLf   = 8'h0A;
   localparam logic [ByteWidth-1:0] CharCr   = 8'h0D;
   localparam logic [ByteWidth-1:0] CharS    = 8'h53;
   localparam logic [ByteWidth-1:0] CharE    = 8'h45;
   localparam logic [ByteWidth-1:0] CharT    = 8'h54;
   localparam logic [ByteWidth-1:0] CharG    = 8'h47;
   localparam logic [ByteWidth-1:0] CharZero = 8'h30;
   localparam logic [ByteWidth-1:0] CharNine = 8'h39;

   localparam logic [BaudWidth-1:0] BaudReset = 16'd38400;

   typedef enum logic [2:0] {
      EV_NONE        = 3'd0,
      EV_BAUD_SET    = 3'd1,
      EV_SET_REJECT  = 3'd2,
      EV_BAUD_REPORT = 3'd3,
      EV_FORWARD     = 3'd4
   } line_event_type;

   typedef struct packed {
      logic                    overflow_cleared;
      line_event_type          line_event;
      logic [BaudWidth-1:0]    baud_value;
      logic [LineLenWidth-1:0] line_length;
   } rsp_type;

endpackage

>>> sv/slcp_if.sv
// Valid/ready channels of the serial line command parser: request and response.
// Depends on slcp_pkg.
interface slcp_req_if;
   logic                          valid;
   logic                          ready;
   logic [slcp_pkg::ByteWidth-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slcp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              overflow_cleared;
   slcp_pkg::line_event_type          line_event;
   logic [slcp_pkg::BaudWidth-1:0]    baud_value;
   logic [slcp_pkg::LineLenWidth-1:0] line_length;

   modport source (output valid, output overflow_cleared, output line_event,
                   output baud_value, output line_length, input ready);
   modport sink   (input valid, input overflow_cleared, input line_event,
                   input baud_value, input line_length, output ready);
endinterface

>>> sv/slcp_line_tracker.sv
// Line state of the parser: count, leading characters, digit value, stored baud.
// Decodes one word per accepted cycle. Depends on slcp_pkg.
module slcp_line_tracker #(
   parameter int unsigned LINE_DEPTH = slcp_pkg::LineDepthDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [slcp_pkg::ByteWidth-1:0] rx_byte,
   output slcp_pkg::rsp_type              result
);
   import slcp_pkg::*;

   localparam int unsigned CountWidth = $clog2(LINE_DEPTH + 1);
   localparam logic [CountWidth-1:0] DepthCount = CountWidth'(LINE_DEPTH);

   logic [CountWidth-1:0]          count_ff, count_in;
   logic [2:0][ByteWidth-1:0]      first_ff, first_in;
   logic [BaudWidth-1:0]           value_ff, value_in;
   logic                           ok_ff, ok_in;
   logic [BaudWidth-1:0]           value_prev_ff, value_prev_in;
   logic                           ok_prev_ff, ok_prev_in;
   logic                           cr_ff, cr_in;
   logic [BaudWidth-1:0]           baud_ff, baud_in;

   logic                           ovf;
   logic [CountWidth-1:0]          n;
   logic [2:0][ByteWidth-1:0]      eff_first;
   logic [BaudWidth-1:0]           eff_value, eff_value_prev;
   logic                           eff_ok, eff_ok_prev, eff_cr;
   logic                           strip;
   logic [CountWidth-1:0]          size;
   logic [BaudWidth-1:0]           sel_value;
   logic                           sel_ok;
   logic [BaudWidth-1:0]           value_x10;

   always_comb begin
      ovf            = (count_ff == DepthCount);
      n              = ovf ? '0 : count_ff;
      eff_first      = ovf ? '0 : first_ff;
      eff_value      = ovf ? '0 : value_ff;
      eff_ok         = ovf ? 1'b1 : ok_ff;
      eff_value_prev = ovf ? '0 : value_prev_ff;
      eff_ok_prev    = ovf ? 1'b1 : ok_prev_ff;
      eff_cr         = ovf ? 1'b0 : cr_ff;

      strip     = eff_cr && (n != '0);
      size      = strip ? n - CountWidth'(1) : n;
      sel_value = strip ? eff_value_prev : eff_value;
      sel_ok    = strip ? eff_ok_prev : eff_ok;
      value_x10 = {eff_value[BaudWidth-4:0], 3'b000} + {eff_value[BaudWidth-2:0], 1'b0};

      result.overflow_cleared = ovf;
      result.line_event       = EV_NONE;
      result.baud_value       = '0;
      result.line_length      = '0;

      count_in      = count_ff;
      first_in      = first_ff;
      value_in      = value_ff;
      ok_in         = ok_ff;
      value_prev_in = value_prev_ff;
      ok_prev_in    = ok_prev_ff;
      cr_in         = cr_ff;
      baud_in       = baud_ff;

      if (rx_byte == CharLf) begin
         result.line_length = LineLenWidth'(size);
         if (size >= CountWidth'(4) && eff_first[0] == CharS && eff_first[1] == CharE
             && eff_first[2] == CharT) begin
            if (sel_ok) begin
               baud_in           = sel_value;
               result.line_event = EV_BAUD_SET;
               result.baud_value = sel_value;
            end else begin
               result.line_event = EV_SET_REJECT;
            end
         end else if (size != '0 && eff_first[0] == CharG) begin
            result.line_event = EV_BAUD_REPORT;
            result.baud_value = baud_ff;
         end else begin
            result.line_event = EV_FORWARD;
         end
         count_in      = '0;
         first_in      = '0;
         value_in      = '0;
         ok_in         = 1'b1;
         value_prev_in = '0;
         ok_prev_in    = 1'b1;
         cr_in         = 1'b0;
      end else begin
         value_prev_in = eff_value;
         ok_prev_in    = eff_ok;
         first_in      = eff_first;
         value_in      = eff_value;
         ok_in         = eff_ok;
         if (n < CountWidth'(3)) begin
            first_in[n[1:0]] = rx_byte;
         end else if (rx_byte inside {[CharZero:CharNine]}) begin
            value_in = value_x10 + BaudWidth'(rx_byte - CharZero);
         end else begin
            ok_in = 1'b0;
         end
         cr_in    = (rx_byte == CharCr);
         count_in = n + CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         first_ff      <= '0;
         value_ff      <= '0;
         ok_ff         <= 1'b1;
         value_prev_ff <= '0;
         ok_prev_ff    <= 1'b1;
         cr_ff         <= 1'b0;
         baud_ff       <= BaudReset;
      end else if (accept) begin
         count_ff      <= count_in;
         first_ff      <= first_in;
         value_ff      <= value_in;
         ok_ff         <= ok_in;
         value_prev_ff <= value_prev_in;
         ok_prev_ff    <= ok_prev_in;
         cr_ff         <= cr_in;
         baud_ff       <= baud_in;
      end
   end

endmodule

>>> sv/serial_line_command_parser.sv
// Top level of the serial line command parser: handshake and response register.
// Depends on slcp_pkg, slcp_if and slcp_line_tracker.
//
// Usage: the req channel carries one received byte per word. Every accepted
// word yields exactly one rsp word: overflow_cleared, line_event, baud_value
// and line_length. An LF ends the line (a CR right before it is stripped);
// SET<digits> stores a new baud, other SET lines longer than SET are rejected,
// a line starting with G reports the stored baud, anything else is forwarded.
// Response: registered; it appears in the cycle after the request word is taken.
// Throughput: one word per cycle while responses are taken; the line state and
// the single response register both update in the accepting cycle.
// Stall: req ready stays high while the response register is empty or is
// being taken in the same cycle; a stalled response holds and blocks input.
// Reset: synchronous; clears the line state, sets the stored baud to 38400
// and empties the response register. No clearing pass is needed.
module serial_line_command_parser #(
   parameter int unsigned LINE_DEPTH = slcp_pkg::LineDepthDefault
) (
   input logic         clock,
   input logic         reset,
   slcp_req_if.sink    req_chan,
   slcp_rsp_if.source  rsp_chan
);
   import slcp_pkg::*;

   logic    accept;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type result;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   slcp_line_tracker #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_tracker (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_chan.rx_byte),
      .result  (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.overflow_cleared = rsp_data_ff.overflow_cleared;
   assign rsp_chan.line_event       = rsp_data_ff.line_event;
   assign rsp_chan.baud_value       = rsp_data_ff.baud_value;
   assign rsp_chan.line_length      = rsp_data_ff.line_length;

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_chan.ready)
      else $error("request blocked with empty response register");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted word produced no response");

   a_overflow_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.overflow_cleared |-> rsp_data_ff.line_length == '0)
      else $error("overflow response with nonzero line length");

   a_set_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.line_event == EV_BAUD_SET
                       || rsp_data_ff.line_event == EV_SET_REJECT)
      |-> rsp_data_ff.line_length >= LineLenWidth'(4))
      else $error("set command shorter than four characters");

endmodule
